/* rtl/core/tpp_pkg.sv */
`default_nettype none
package tpp_pkg;

	// Byte counter width: the longest packet is 65542 bytes.
	localparam int unsigned POS_W = 17;

	localparam logic [POS_W-1:0] HEADER_BYTES = 17'd10;
	localparam logic [15:0]      MIN_LENGTH   = 16'd5;
	localparam logic [15:0]      CRC_INIT     = 16'hFFFF;
	localparam logic [15:0]      CRC_POLY     = 16'h1021;

	// Positions of the primary header words inside the packet.
	localparam logic [POS_W-1:0] POS_SEQ_CTRL = 17'd2;
	localparam logic [POS_W-1:0] POS_LENGTH   = 17'd4;
	localparam logic [POS_W-1:0] POS_DATA_HDR = 17'd6;

	// Decoded fields of one finished packet.
	typedef struct packed {
		logic [10:0] apid;
		logic [1:0]  seq_flags;
		logic [13:0] seq_count;
		logic [15:0] packet_length;
		logic [3:0]  ack_flags;
		logic [7:0]  svc_type;
		logic [7:0]  svc_subtype;
		logic [7:0]  sender_id;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
		logic        crc_ok;
		logic        length_error;
	} tpp_result_t;

endpackage
`default_nettype wire

/* rtl/core/tpp_if.sv */
`default_nettype none
// Byte stream channel into the parser.
interface tpp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// Result channel carrying the decoded packet fields.
interface tpp_res_if;
	logic        valid;
	logic        ready;
	logic [10:0] apid;
	logic [1:0]  seq_flags;
	logic [13:0] seq_count;
	logic [15:0] packet_length;
	logic [3:0]  ack_flags;
	logic [7:0]  svc_type;
	logic [7:0]  svc_subtype;
	logic [7:0]  sender_id;
	logic [15:0] received_crc;
	logic [15:0] computed_crc;
	logic        crc_ok;
	logic        length_error;

	modport source (output valid, output apid, output seq_flags, output seq_count,
		output packet_length, output ack_flags, output svc_type,
		output svc_subtype, output sender_id, output received_crc,
		output computed_crc, output crc_ok, output length_error, input ready);
	modport sink (input valid, input apid, input seq_flags, input seq_count,
		input packet_length, input ack_flags, input svc_type,
		input svc_subtype, input sender_id, input received_crc,
		input computed_crc, input crc_ok, input length_error, output ready);
endinterface
`default_nettype wire

/* rtl/core/tpp_crc8.sv */
`default_nettype none
// CRC-16 update by one whole byte, MSB first, eight shift steps unrolled.
module tpp_crc8
	import tpp_pkg::*;
(
	input  wire logic [15:0] crc,
	input  wire logic [7:0]  data,
	output logic [15:0]      crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule
`default_nettype wire

/* rtl/core/tpp_parser.sv */
`default_nettype none
// Input register, byte position tracking, header capture and running CRC.
module tpp_parser
	import tpp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [7:0]  in_byte,
	output logic             in_ready,
	input  wire logic        res_free,
	output logic             res_load,
	output tpp_result_t      result
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      packet_id_q;
	logic [15:0]      seq_ctrl_q;
	logic [15:0]      length_q;
	logic [31:0]      data_hdr_q;
	logic [15:0]      crc_q;
	logic [7:0]       crc_high_q;

	logic             in_header;
	logic             short_len;
	logic [POS_W-1:0] data_end;
	logic             in_data;
	logic             at_crc_high;
	logic             emit;
	logic             advance;
	logic [15:0]      crc_next;
	logic [15:0]      received;

	tpp_crc8 u_crc8 (
		.crc      (crc_q),
		.data     (byte_s1),
		.crc_next (crc_next)
	);

	// Classify the byte held in the input register by its packet position.
	assign in_header   = pos_q < HEADER_BYTES;
	assign short_len   = length_q < MIN_LENGTH;
	assign data_end    = short_len ? HEADER_BYTES : ({1'b0, length_q} + {1'b0, MIN_LENGTH});
	assign in_data     = !in_header && (pos_q < data_end);
	assign at_crc_high = !in_header && (pos_q == data_end);
	assign emit        = valid_s1 && !in_header && !in_data && !at_crc_high;

	// The held byte retires unless it finishes a packet and the result slot is full.
	assign advance  = valid_s1 && (!emit || res_free);
	assign in_ready = !valid_s1 || advance;
	assign res_load = emit && advance;

	// Assemble the result from the captured fields and the final byte.
	assign received = {crc_high_q, byte_s1};
	always_comb begin
		result.apid          = packet_id_q[10:0];
		result.seq_flags     = seq_ctrl_q[15:14];
		result.seq_count     = seq_ctrl_q[13:0];
		result.packet_length = length_q;
		result.ack_flags     = data_hdr_q[27:24];
		result.svc_type      = data_hdr_q[23:16];
		result.svc_subtype   = data_hdr_q[15:8];
		result.sender_id     = data_hdr_q[7:0];
		result.received_crc  = received;
		result.computed_crc  = crc_q;
		result.crc_ok        = !short_len && (crc_q == received);
		result.length_error  = short_len;
	end

	// Input register and packet state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			byte_s1     <= 8'h00;
			pos_q       <= '0;
			packet_id_q <= 16'h0000;
			seq_ctrl_q  <= 16'h0000;
			length_q    <= 16'h0000;
			data_hdr_q  <= 32'h0000_0000;
			crc_q       <= CRC_INIT;
			crc_high_q  <= 8'h00;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
				byte_s1  <= in_byte;
			end
			if (advance) begin
				priority if (in_header) begin
					priority if (pos_q < POS_SEQ_CTRL) begin
						packet_id_q <= {packet_id_q[7:0], byte_s1};
					end else if (pos_q < POS_LENGTH) begin
						seq_ctrl_q <= {seq_ctrl_q[7:0], byte_s1};
					end else if (pos_q < POS_DATA_HDR) begin
						length_q <= {length_q[7:0], byte_s1};
					end else begin
						data_hdr_q <= {data_hdr_q[23:0], byte_s1};
					end
					crc_q <= crc_next;
					pos_q <= pos_q + POS_W'(1);
				end else if (in_data) begin
					crc_q <= crc_next;
					pos_q <= pos_q + POS_W'(1);
				end else if (at_crc_high) begin
					crc_high_q <= byte_s1;
					pos_q      <= pos_q + POS_W'(1);
				end else begin
					pos_q <= '0;
					crc_q <= CRC_INIT;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/telecommand_packet_parser_crc_unit.sv */
`default_nettype none
// Telecommand packet parser: takes one byte request per cycle from a stream of
// back-to-back packets and, on the last byte of each packet, delivers one result
// request with the decoded header fields, the received and computed CRC-16 and
// the check flags. Throughput is one byte per cycle, limited by the combinational
// eight-step CRC update; the last byte of a packet passes the input register and
// its result is then held in the result register. The result register frees the
// input side, so bytes keep flowing while a result waits, and only the final byte
// of the next packet stalls behind an untaken result.
module telecommand_packet_parser_crc_unit
	import tpp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	tpp_in_if.sink     cmd,
	tpp_res_if.source  res
);

	logic        res_free;
	logic        res_load;
	logic        res_valid_q;
	tpp_result_t result;
	tpp_result_t res_q;

	tpp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_byte  (cmd.data_byte),
		.in_ready (cmd.ready),
		.res_free (res_free),
		.res_load (res_load),
		.result   (result)
	);

	// Result register with its valid flag.
	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_free) begin
				res_valid_q <= res_load;
			end
			if (res_load) begin
				res_q <= result;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.apid          = res_q.apid;
	assign res.seq_flags     = res_q.seq_flags;
	assign res.seq_count     = res_q.seq_count;
	assign res.packet_length = res_q.packet_length;
	assign res.ack_flags     = res_q.ack_flags;
	assign res.svc_type      = res_q.svc_type;
	assign res.svc_subtype   = res_q.svc_subtype;
	assign res.sender_id     = res_q.sender_id;
	assign res.received_crc  = res_q.received_crc;
	assign res.computed_crc  = res_q.computed_crc;
	assign res.crc_ok        = res_q.crc_ok;
	assign res.length_error  = res_q.length_error;

endmodule
`default_nettype wire

/* tb/testbench.sv */
module testbench
	import tpp_pkg::*;
();

	// How the error control word of a packet is formed.
	typedef enum logic [1:0] {
		CRC_GOOD,
		CRC_BAD,
		CRC_GIVEN
	} crc_kind_t;

	// One packet to send: header words, payload, error control word and, for
	// some directed rows, the result as it can be read off the header.
	typedef struct {
		logic [15:0] pid;
		logic [15:0] seq;
		logic [15:0] len;
		logic [31:0] dfh;
		logic [7:0]  fill;
		bit          rand_app;
		crc_kind_t   kind;
		logic [15:0] crc_word;
		bit          typed;
		tpp_result_t typed_res;
	} packet_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tpp_in_if  cmd_if();
	tpp_res_if res_if();

	telecommand_packet_parser_crc_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Parser state mirrored by the testbench.
	logic [POS_W-1:0] parse_pos;
	logic [15:0]      parse_pid;
	logic [15:0]      parse_seq;
	logic [15:0]      parse_len;
	logic [31:0]      parse_dfh;
	logic [15:0]      parse_crc;
	logic [7:0]       parse_crc_hi;

	tpp_result_t packets_due[$];
	tpp_result_t want_res;
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          packets_sent = 0;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Directed packets: both short-length cases with the result typed in, then
	// the shortest valid packet with a good word and a short payload with a bad one.
	packet_row_t directed_rows [4] = '{
		'{pid: 16'h0000, seq: 16'h0000, len: 16'h0000, dfh: 32'h0000_0000, fill: 8'h00,
			rand_app: 1'b0, kind: CRC_GIVEN, crc_word: 16'h0000, typed: 1'b1,
			typed_res: '{apid: 11'h000, seq_flags: 2'd0, seq_count: 14'h0000,
				packet_length: 16'h0000, ack_flags: 4'h0, svc_type: 8'h00,
				svc_subtype: 8'h00, sender_id: 8'h00, received_crc: 16'h0000,
				computed_crc: 16'h0000, crc_ok: 1'b0, length_error: 1'b1}},
		'{pid: 16'hFFFF, seq: 16'hFFFF, len: 16'h0004, dfh: 32'hFFFF_FFFF, fill: 8'hFF,
			rand_app: 1'b0, kind: CRC_GIVEN, crc_word: 16'hFFFF, typed: 1'b1,
			typed_res: '{apid: 11'h7FF, seq_flags: 2'd3, seq_count: 14'h3FFF,
				packet_length: 16'h0004, ack_flags: 4'hF, svc_type: 8'hFF,
				svc_subtype: 8'hFF, sender_id: 8'hFF, received_crc: 16'hFFFF,
				computed_crc: 16'h0000, crc_ok: 1'b0, length_error: 1'b1}},
		'{pid: 16'h01A5, seq: 16'hC00F, len: 16'h0005, dfh: 32'h1A22_3344, fill: 8'h00,
			rand_app: 1'b0, kind: CRC_GOOD, crc_word: 16'h0000, typed: 1'b0,
			typed_res: '0},
		'{pid: 16'h0800, seq: 16'h4001, len: 16'h0007, dfh: 32'hF080_017E, fill: 8'hA5,
			rand_app: 1'b0, kind: CRC_BAD, crc_word: 16'h0000, typed: 1'b0,
			typed_res: '0}
	};

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic void parser_clear();
		parse_pos    = '0;
		parse_pid    = '0;
		parse_seq    = '0;
		parse_len    = '0;
		parse_dfh    = '0;
		parse_crc    = CRC_INIT;
		parse_crc_hi = '0;
	endfunction

	// Advances the mirrored parser by one byte; returns 1 with the decoded
	// packet when the byte closes a packet.
	function automatic bit parse_byte(input logic [7:0] b, output tpp_result_t r);
		logic [POS_W-1:0] data_end;
		logic             short_len;
		logic [15:0]      rx;
		r = '0;
		if (parse_pos < HEADER_BYTES) begin
			if (parse_pos < POS_SEQ_CTRL) begin
				parse_pid = {parse_pid[7:0], b};
			end else if (parse_pos < POS_LENGTH) begin
				parse_seq = {parse_seq[7:0], b};
			end else if (parse_pos < POS_DATA_HDR) begin
				parse_len = {parse_len[7:0], b};
			end else begin
				parse_dfh = {parse_dfh[23:0], b};
			end
			parse_crc = crc16_byte(parse_crc, b);
			parse_pos = parse_pos + POS_W'(1);
			return 1'b0;
		end

		// A length below the minimum means no payload at all.
		short_len = parse_len < MIN_LENGTH;
		data_end  = short_len ? HEADER_BYTES : ({1'b0, parse_len} + {1'b0, MIN_LENGTH});

		if (parse_pos < data_end) begin
			parse_crc = crc16_byte(parse_crc, b);
			parse_pos = parse_pos + POS_W'(1);
			return 1'b0;
		end
		if (parse_pos == data_end) begin
			parse_crc_hi = b;
			parse_pos    = parse_pos + POS_W'(1);
			return 1'b0;
		end

		rx              = {parse_crc_hi, b};
		r.apid          = parse_pid[10:0];
		r.seq_flags     = parse_seq[15:14];
		r.seq_count     = parse_seq[13:0];
		r.packet_length = parse_len;
		r.ack_flags     = parse_dfh[27:24];
		r.svc_type      = parse_dfh[23:16];
		r.svc_subtype   = parse_dfh[15:8];
		r.sender_id     = parse_dfh[7:0];
		r.received_crc  = rx;
		r.computed_crc  = parse_crc;
		r.crc_ok        = !short_len && (parse_crc == rx);
		r.length_error  = short_len;
		parse_pos = '0;
		parse_crc = CRC_INIT;
		return 1'b1;
	endfunction

	// Offers one byte request, with random idle cycles ahead of it, and
	// updates the mirrored parser once it is taken.
	task automatic send_byte(input logic [7:0] b, output bit has_res, output tpp_result_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.data_byte <= b;
		do @(posedge clk); while (!cmd_if.ready);
		bytes_sent++;
		has_res = parse_byte(b, r);
	endtask

	task automatic send_packet(input packet_row_t row);
		logic [79:0] hdr;
		int          n_app;
		logic [15:0] word;
		logic [15:0] computed;
		bit          has_res;
		tpp_result_t r;
		hdr   = {row.pid, row.seq, row.len, row.dfh};
		n_app = (row.len < MIN_LENGTH) ? 0 : int'(row.len) - int'(MIN_LENGTH);
		for (int i = 0; i < 10; i++) begin
			send_byte(hdr[79 - 8 * i -: 8], has_res, r);
		end
		for (int j = 0; j < n_app; j++) begin
			send_byte(row.rand_app ? 8'($urandom) : row.fill, has_res, r);
		end

		// The running CRC is complete here, so a good word can be formed.
		case (row.kind)
			CRC_GOOD: word = parse_crc;
			CRC_BAD:  word = parse_crc ^ (16'h0001 << $urandom_range(15));
			default:  word = row.crc_word;
		endcase
		send_byte(word[15:8], has_res, r);
		send_byte(word[7:0], has_res, r);
		if (has_res) begin
			if (row.typed) begin
				computed       = r.computed_crc;
				r              = row.typed_res;
				r.computed_crc = computed;
			end
			packets_due.push_back(r);
		end
		packets_sent++;
	endtask

	// Mostly well-formed packets with random content; some carry a short
	// length, a corrupted word or an arbitrary word.
	function automatic packet_row_t random_row();
		packet_row_t row;
		int unsigned pick;
		row.pid      = 16'($urandom);
		row.seq      = 16'($urandom);
		row.dfh      = $urandom;
		row.fill     = 8'h00;
		row.rand_app = 1'b1;
		row.typed    = 1'b0;
		row.typed_res = '0;
		row.crc_word = 16'($urandom);
		pick = $urandom_range(99);
		row.len = (pick < 12) ? 16'($urandom_range(4)) : 16'($urandom_range(20, 5));
		pick = $urandom_range(99);
		row.kind = (pick < 70) ? CRC_GOOD : (pick < 85) ? CRC_BAD : CRC_GIVEN;
		return row;
	endfunction

	// Holds the byte stream back until every pending result has been taken.
	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (packets_due.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result receiver with random back-pressure.
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each taken result request with the oldest pending packet.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (packets_due.size() == 0) begin
				$error("result request with no packet pending");
				mismatches++;
			end else begin
				want_res = packets_due.pop_front();
				check_field("apid", 16'(want_res.apid), 16'(res_if.apid));
				check_field("seq_flags", 16'(want_res.seq_flags), 16'(res_if.seq_flags));
				check_field("seq_count", 16'(want_res.seq_count), 16'(res_if.seq_count));
				check_field("packet_length", want_res.packet_length, res_if.packet_length);
				check_field("ack_flags", 16'(want_res.ack_flags), 16'(res_if.ack_flags));
				check_field("svc_type", 16'(want_res.svc_type), 16'(res_if.svc_type));
				check_field("svc_subtype", 16'(want_res.svc_subtype),
					16'(res_if.svc_subtype));
				check_field("sender_id", 16'(want_res.sender_id), 16'(res_if.sender_id));
				check_field("received_crc", want_res.received_crc, res_if.received_crc);
				check_field("computed_crc", want_res.computed_crc, res_if.computed_crc);
				check_field("crc_ok", 16'(want_res.crc_ok), 16'(res_if.crc_ok));
				check_field("length_error", 16'(want_res.length_error),
					16'(res_if.length_error));
			end
		end
	end

	initial begin
		int unsigned send_pct [3];
		int unsigned recv_pct [3];
		int          phase_bytes;
		int          phase_packets;
		send_pct = '{12, 83, 0};
		recv_pct = '{83, 12, 0};
		arst_n           = 1'b0;
		cmd_if.valid     = 1'b0;
		cmd_if.data_byte = 8'h00;
		res_if.ready     = 1'b0;
		send_idle_pct    = send_pct[0];
		recv_stall_pct   = recv_pct[0];
		parser_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			phase_bytes    = bytes_sent;
			phase_packets  = packets_sent;
			if (ph == 0) begin
				foreach (directed_rows[i]) begin
					send_packet(directed_rows[i]);
				end
			end
			while (bytes_sent - phase_bytes < 250 || packets_sent - phase_packets < 12) begin
				send_packet(random_row());
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#8000000;
		$display("testbench failed");
		$finish;
	end

endmodule
